FILE: sv/quoted_token_splitter_assert.svh
// ----------------------------------------------------------------------------
// Quoted token splitter assertion macros
// Concurrent check macros; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef QUOTED_TOKEN_SPLITTER_ASSERT_SVH
`define QUOTED_TOKEN_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// next-cycle implication
`define QTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define QTS_ASSERT_IMP(label, clk, rst, ante, cons)
`define QTS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/qts_pkg.sv
// ----------------------------------------------------------------------------
// Quoted token splitter package
// Shared result type, token kinds and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

   localparam logic [1:0] KIND_PLAIN = 2'd0;
   localparam logic [1:0] KIND_DQ    = 2'd1;
   localparam logic [1:0] KIND_SQ    = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] token_kind;
      logic       has_byte;
      logic [7:0] out_byte;
      logic       token_end;
   } result_type;

   // results produced by one scan step
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

`default_nettype wire

FILE: sv/qts_scan.sv
// ----------------------------------------------------------------------------
// Quoted token splitter scanner
// Mode register and per-byte token logic; up to two results a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qts_scan (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step,
   input  wire  [7:0]               source_byte,
   input  wire                      end_of_input,
   output qts_pkg::result_pair_type results
);
   import qts_pkg::*;

   typedef enum logic [3:0] {
      MODE_START, MODE_IDLE, MODE_TOKEN, MODE_DQ, MODE_SQ,
      MODE_SLASH, MODE_CMT, MODE_CMT_STAR
   } mode_type;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;

   mode_type mode_ff, mode_in;
   logic     is_space;

   function automatic result_type byte_res(logic [1:0] kind, logic [7:0] b);
      byte_res = '{token_kind: kind, has_byte: 1'b1, out_byte: b, token_end: 1'b0};
   endfunction

   function automatic result_type end_res(logic [1:0] kind);
      end_res = '{token_kind: kind, has_byte: 1'b0, out_byte: 8'd0, token_end: 1'b1};
   endfunction

   assign is_space = source_byte inside {8'h20, 8'h09, 8'h0A, 8'h00};

   always_comb begin
      mode_in        = mode_ff;
      results.count  = 2'd0;
      results.first  = end_res(KIND_PLAIN);
      results.second = end_res(KIND_PLAIN);
      if (end_of_input) begin
         mode_in = MODE_START;
         case (mode_ff)
            MODE_TOKEN: begin
               results.count = 2'd1;
            end
            MODE_DQ: begin
               results.count = 2'd1;
               results.first = end_res(KIND_DQ);
            end
            MODE_SQ: begin
               results.count = 2'd1;
               results.first = end_res(KIND_SQ);
            end
            MODE_SLASH: begin
               results.count = 2'd2;
               results.first = byte_res(KIND_PLAIN, CH_SLASH);
            end
            default: ;
         endcase
      end else begin
         case (mode_ff)
            MODE_START, MODE_IDLE: begin
               if (source_byte == CH_DQ) begin
                  mode_in = MODE_DQ;
               end else if (source_byte == CH_SQ) begin
                  mode_in = MODE_SQ;
               end else if (source_byte == CH_SLASH) begin
                  mode_in = MODE_SLASH;
               end else if (is_space) begin
                  // only the very start of text gives an empty token
                  if (mode_ff == MODE_START) results.count = 2'd1;
                  mode_in = MODE_IDLE;
               end else begin
                  results.count = 2'd1;
                  results.first = byte_res(KIND_PLAIN, source_byte);
                  mode_in       = MODE_TOKEN;
               end
            end
            MODE_TOKEN: begin
               results.count = 2'd1;
               if (is_space) begin
                  mode_in = MODE_IDLE;
               end else begin
                  results.first = byte_res(KIND_PLAIN, source_byte);
               end
            end
            MODE_DQ: begin
               results.count = 2'd1;
               if (source_byte == CH_DQ) begin
                  results.first = end_res(KIND_DQ);
                  mode_in       = MODE_IDLE;
               end else begin
                  results.first = byte_res(KIND_DQ, source_byte);
               end
            end
            MODE_SQ: begin
               results.count = 2'd1;
               if (source_byte == CH_SQ) begin
                  results.first = end_res(KIND_SQ);
                  mode_in       = MODE_IDLE;
               end else begin
                  results.first = byte_res(KIND_SQ, source_byte);
               end
            end
            MODE_SLASH: begin
               if (source_byte == CH_STAR) begin
                  mode_in = MODE_CMT;
               end else if (is_space) begin
                  results.count = 2'd2;
                  results.first = byte_res(KIND_PLAIN, CH_SLASH);
                  mode_in       = MODE_IDLE;
               end else begin
                  results.count  = 2'd2;
                  results.first  = byte_res(KIND_PLAIN, CH_SLASH);
                  results.second = byte_res(KIND_PLAIN, source_byte);
                  mode_in        = MODE_TOKEN;
               end
            end
            MODE_CMT: begin
               if (source_byte == CH_STAR) mode_in = MODE_CMT_STAR;
            end
            MODE_CMT_STAR: begin
               if (source_byte == CH_SLASH) begin
                  mode_in = MODE_IDLE;
               end else if (source_byte != CH_STAR) begin
                  mode_in = MODE_CMT;
               end
            end
            default: begin
               mode_in = MODE_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
      end else if (step) begin
         mode_ff <= mode_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/qts_rsp_queue.sv
// ----------------------------------------------------------------------------
// Quoted token splitter result queue
// Small queue taking up to two results a cycle, draining one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qts_rsp_queue (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  wire qts_pkg::result_pair_type    push_data,
   input  wire                              pop,
   output qts_pkg::result_type              head,
   output logic [qts_pkg::QUEUE_CW-1:0]     count
);
   import qts_pkg::*;

   result_type          mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic [1:0]          n_push;
   logic [QUEUE_AW-1:0] wr_next;

   assign n_push    = push ? push_data.count : 2'd0;
   assign wr_next   = wr_ptr_ff + QUEUE_AW'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_AW'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_AW'(pop);
   assign count_in  = count_ff + QUEUE_CW'(n_push) - QUEUE_CW'(pop);
   assign head      = mem[rd_ptr_ff];
   assign count     = count_ff;

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) mem[wr_ptr_ff] <= push_data.first;
      if (n_push == 2'd2) mem[wr_next]   <= push_data.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/quoted_token_splitter.sv
// ----------------------------------------------------------------------------
// Quoted token splitter
// Splits a byte stream into plain, double- and single-quoted tokens.
// ----------------------------------------------------------------------------
// Path: a request is registered in the input register, scanned from there, and its
//   results are registered in the result queue, whose head drives rsp.
// Throughput: one request per cycle while the queue has room; output drains
//   one result per cycle, so two-result requests (slash cases) are paced by the result port.
// Reset: synchronous, active high; empties the queue and input register
//   and puts the scanner at start of text.
`timescale 1ns / 1ps
`default_nettype none

`include "quoted_token_splitter_assert.svh"

module quoted_token_splitter (
   input  wire        clock,
   input  wire        reset,
   // request channel
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] source_byte
   input  wire        req_tlast,   // end_of_input
   // result channel
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [1:0] token_kind, [2] has_byte
   output logic       rsp_tlast    // token_end
);
   import qts_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;

   logic                  advance;
   logic                  room;
   logic                  rsp_pop;
   result_pair_type       scan_res;
   result_type            head;
   logic [QUEUE_CW-1:0]   q_count;

   // a scan step may push two results; leave space for both
   assign room    = q_count <= QUEUE_CW'(QUEUE_DEPTH - 2);
   assign advance = in_valid_ff && room;

   // new request enters while the held one moves on
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
      end
   end

   qts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .source_byte  (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .results      (scan_res)
   );

   assign rsp_pop = rsp_tvalid && rsp_tready;

   qts_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (scan_res),
      .pop       (rsp_pop),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_tvalid = q_count != '0;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = {head.has_byte, head.token_kind};
   assign rsp_tlast  = head.token_end;

   // queue never overfills
   `QTS_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, q_count <= QUEUE_CW'(QUEUE_DEPTH))
   // an end mark never carries a byte
   `QTS_ASSERT_IMP(a_end_no_byte, clock, reset, rsp_tvalid && rsp_tlast,
      !rsp_tuser[2] && rsp_tdata == 8'd0)
   // a held request stays until the scanner takes it
   `QTS_ASSERT_NXT(a_input_held, clock, reset, in_valid_ff && !advance, in_valid_ff)
   // an empty queue with nothing scanned stays empty
   `QTS_ASSERT_NXT(a_no_phantom, clock, reset, !rsp_tvalid && !advance, !rsp_tvalid)

endmodule

`default_nettype wire

FILE: verif/quoted_token_splitter_test.sv
// ----------------------------------------------------------------------------
// Quoted token splitter testbench
// Streams directed and random source text into the splitter, predicts each
// token byte and end mark in a scoreboard, and compares every result taken
// from the rsp channel. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_token_splitter_test;
   import qts_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS  = 850;
   localparam int DRAIN_CYCLES  = 10;
   localparam int REPORT_LIMIT  = 10;

   // characters the scanner treats specially
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   typedef enum logic [3:0] {
      SCAN_START,
      SCAN_BETWEEN,
      SCAN_PLAIN,
      SCAN_DQ,
      SCAN_SQ,
      SCAN_SLASH,
      SCAN_COMMENT,
      SCAN_COMMENT_STAR
   } scan_mode_type;

   typedef struct {
      logic [7:0] src;
      logic       eoi;
   } request_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] source_byte
   logic       req_tlast;   // end_of_input
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic [2:0] rsp_tuser;   // [1:0] token_kind, [2] has_byte
   logic       rsp_tlast;   // token_end

   request_type source_text_q[$];
   int          cycle_count;
   bit          long_stall_done;

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_NUL;
   endfunction

   // Tracks the scan mode and queues the results each request should give.
   class token_scoreboard;
      result_type    expected_tokens[$];
      scan_mode_type mode;
      int            failures;
      int            reported;

      function new();
         mode     = SCAN_START;
         failures = 0;
         reported = 0;
      endfunction

      function void push_byte(logic [1:0] kind, logic [7:0] c);
         result_type r;
         r.token_kind = kind;
         r.has_byte   = 1'b1;
         r.out_byte   = c;
         r.token_end  = 1'b0;
         expected_tokens.push_back(r);
      endfunction

      function void push_end(logic [1:0] kind);
         result_type r;
         r.token_kind = kind;
         r.has_byte   = 1'b0;
         r.out_byte   = 8'h00;
         r.token_end  = 1'b1;
         expected_tokens.push_back(r);
      endfunction

      function void note_request(logic [7:0] c, logic eoi);
         if (eoi) begin
            // close whatever is open; a comment just ends
            case (mode)
               SCAN_PLAIN: push_end(KIND_PLAIN);
               SCAN_DQ:    push_end(KIND_DQ);
               SCAN_SQ:    push_end(KIND_SQ);
               SCAN_SLASH: begin
                  push_byte(KIND_PLAIN, CH_SLASH);
                  push_end(KIND_PLAIN);
               end
               default: ;
            endcase
            mode = SCAN_START;
         end else begin
            case (mode)
               SCAN_START, SCAN_BETWEEN: begin
                  if (c == CH_DQUOTE) begin
                     mode = SCAN_DQ;
                  end else if (c == CH_SQUOTE) begin
                     mode = SCAN_SQ;
                  end else if (c == CH_SLASH) begin
                     mode = SCAN_SLASH;
                  end else if (is_blank(c)) begin
                     // whitespace at the start of text yields one empty token
                     if (mode == SCAN_START) push_end(KIND_PLAIN);
                     mode = SCAN_BETWEEN;
                  end else begin
                     push_byte(KIND_PLAIN, c);
                     mode = SCAN_PLAIN;
                  end
               end
               SCAN_PLAIN: begin
                  if (is_blank(c)) begin
                     push_end(KIND_PLAIN);
                     mode = SCAN_BETWEEN;
                  end else begin
                     push_byte(KIND_PLAIN, c);
                  end
               end
               SCAN_DQ: begin
                  if (c == CH_DQUOTE) begin
                     push_end(KIND_DQ);
                     mode = SCAN_BETWEEN;
                  end else begin
                     push_byte(KIND_DQ, c);
                  end
               end
               SCAN_SQ: begin
                  if (c == CH_SQUOTE) begin
                     push_end(KIND_SQ);
                     mode = SCAN_BETWEEN;
                  end else begin
                     push_byte(KIND_SQ, c);
                  end
               end
               SCAN_SLASH: begin
                  if (c == CH_STAR) begin
                     mode = SCAN_COMMENT;
                  end else if (is_blank(c)) begin
                     push_byte(KIND_PLAIN, CH_SLASH);
                     push_end(KIND_PLAIN);
                     mode = SCAN_BETWEEN;
                  end else begin
                     push_byte(KIND_PLAIN, CH_SLASH);
                     push_byte(KIND_PLAIN, c);
                     mode = SCAN_PLAIN;
                  end
               end
               SCAN_COMMENT: begin
                  if (c == CH_STAR) mode = SCAN_COMMENT_STAR;
               end
               SCAN_COMMENT_STAR: begin
                  if (c == CH_SLASH) mode = SCAN_BETWEEN;
                  else if (c != CH_STAR) mode = SCAN_COMMENT;
               end
               default: mode = SCAN_START;
            endcase
         end
      endfunction

      function void report(string what, result_type want, result_type got);
         failures++;
         if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t %s: expected kind %0d has_byte %0b byte %02h end %0b, ",
                     $realtime, what, want.token_kind, want.has_byte, want.out_byte,
                     want.token_end,
                     "got kind %0d has_byte %0b byte %02h end %0b",
                     got.token_kind, got.has_byte, got.out_byte, got.token_end);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_tokens.size() == 0) begin
            want = '0;
            report("result with none pending", want, got);
         end else begin
            want = expected_tokens.pop_front();
            if (want.token_kind !== got.token_kind || want.has_byte !== got.has_byte ||
                want.out_byte !== got.out_byte || want.token_end !== got.token_end)
               report("mismatch", want, got);
         end
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      function void flag_leftover();
         if (expected_tokens.size() != 0) begin
            failures += expected_tokens.size();
            $display("%0d expected results never arrived", expected_tokens.size());
         end
      endfunction
   endclass

   token_scoreboard scoreboard;

   quoted_token_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Cycle counter doubles as the watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Monitor: requests go to the predictor before results are checked, so a
   // same-edge pair can never be seen out of order.
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) scoreboard.note_request(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.token_kind = rsp_tuser[1:0];
            got.has_byte   = rsp_tuser[2];
            got.out_byte   = rsp_tdata;
            got.token_end  = rsp_tlast;
            scoreboard.check_result(got);
         end
      end
   end

   // Result side: the ready style is re-picked at random as the cycle counter runs; one forced long
   // stall early in the random part fills the block and backs up req.
   initial begin
      int stall_left;
      int ready_style;
      stall_left  = 0;
      ready_style = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count % 64 == 0) ready_style = $urandom_range(0, 3);
         if (stall_left == 0 && !reset) begin
            if (!long_stall_done && cycle_count >= 600) begin
               long_stall_done = 1'b1;
               stall_left      = $urandom_range(120, 200);
            end else if ($urandom_range(0, 999) == 0) begin
               stall_left = $urandom_range(40, 100);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (ready_style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 1) == 1);
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= cycle_count[1];
            endcase
         end
      end
   end

   task automatic add_request(logic [7:0] src, logic eoi);
      request_type r;
      r.src = src;
      r.eoi = eoi;
      source_text_q.push_back(r);
   endtask

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_NL;
         default: return CH_NUL;
      endcase
   endfunction

   // any byte that does not end a plain token, biased toward special ones
   function automatic logic [7:0] pick_token_byte();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0:       c = CH_DQUOTE;
         1:       c = CH_SQUOTE;
         2:       c = CH_SLASH;
         3:       c = CH_STAR;
         4:       c = 8'hFF;
         default: c = 8'($urandom_range(0, 255));
      endcase
      while (is_blank(c)) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic build_directed();
      add_request(CH_SPACE, 1'b0);     // leading whitespace: empty token
      add_request("a", 1'b0);
      add_request(CH_DQUOTE, 1'b0);    // quote inside a plain token
      add_request(8'hFF, 1'b0);        // 0xFF is an ordinary byte
      add_request(CH_NUL, 1'b0);       // NUL ends the token
      add_request(CH_DQUOTE, 1'b0);
      add_request(CH_DQUOTE, 1'b0);    // empty double quotes
      add_request(CH_SQUOTE, 1'b0);
      add_request(CH_TAB, 1'b0);       // whitespace kept inside quotes
      add_request(8'h5A, 1'b1);        // end of text inside single quotes
      add_request(CH_SLASH, 1'b0);
      add_request(CH_NL, 1'b0);        // lone slash before whitespace
      add_request(CH_SLASH, 1'b0);
      add_request(CH_STAR, 1'b0);      // comment opens
      add_request(CH_SLASH, 1'b0);     // slash-star-slash does not close
      add_request(CH_STAR, 1'b0);
      add_request(CH_STAR, 1'b0);
      add_request(CH_SLASH, 1'b0);     // comment closes
      add_request(CH_SLASH, 1'b0);
      add_request("x", 1'b0);          // slash then byte: two results
      add_request(8'hFF, 1'b1);        // end of text inside a token
      add_request(CH_SLASH, 1'b0);
      add_request(8'h00, 1'b1);        // end of text after a lone slash
      add_request(CH_SLASH, 1'b0);
      add_request(CH_STAR, 1'b0);
      add_request(8'hA5, 1'b1);        // end of text inside a comment
      add_request(CH_DQUOTE, 1'b0);
      add_request(8'h3C, 1'b1);        // end of text inside double quotes
   endtask

   // Mostly well-formed fragments with random content, plus raw noise.
   task automatic build_random();
      int         target;
      int         n;
      logic [7:0] c;
      logic [7:0] q;
      target = source_text_q.size() + RANDOM_ITEMS;
      while (source_text_q.size() < target) begin
         case ($urandom_range(0, 11))
            0, 1, 2: begin
               c = pick_token_byte();
               while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_SLASH) c = pick_token_byte();
               add_request(c, 1'b0);
               n = $urandom_range(0, 5);
               repeat (n) add_request(pick_token_byte(), 1'b0);
            end
            3, 4, 5: begin
               q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
               add_request(q, 1'b0);
               n = $urandom_range(0, 5);
               repeat (n) begin
                  c = ($urandom_range(0, 4) == 0) ? pick_blank() : pick_token_byte();
                  if (c == q) c = 8'h41;
                  add_request(c, 1'b0);
               end
               if ($urandom_range(0, 9) != 0) add_request(q, 1'b0);
            end
            6, 7: begin
               add_request(CH_SLASH, 1'b0);
               add_request(CH_STAR, 1'b0);
               n = $urandom_range(0, 8);
               repeat (n) begin
                  case ($urandom_range(0, 3))
                     0:       add_request(CH_STAR, 1'b0);
                     1:       add_request(CH_SLASH, 1'b0);
                     default: add_request(8'($urandom_range(0, 255)), 1'b0);
                  endcase
               end
               if ($urandom_range(0, 9) != 0) begin
                  add_request(CH_STAR, 1'b0);
                  add_request(CH_SLASH, 1'b0);
               end
            end
            8, 9: begin
               add_request(CH_SLASH, 1'b0);
               if ($urandom_range(0, 2) == 0) begin
                  add_request(pick_blank(), 1'b0);
               end else begin
                  c = pick_token_byte();
                  if (c == CH_STAR) c = CH_SLASH;
                  add_request(c, 1'b0);
                  n = $urandom_range(0, 3);
                  repeat (n) add_request(pick_token_byte(), 1'b0);
               end
            end
            10: begin
               add_request(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
               n = $urandom_range(1, 4);
               repeat (n) add_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
         endcase
         if ($urandom_range(0, 99) < 85) begin
            n = $urandom_range(1, 3);
            repeat (n) add_request(pick_blank(), 1'b0);
         end
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(request_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= r.src;
      req_tlast  <= r.eoi;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic hold_sender(int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   initial begin
      int idx;
      int burst;
      int gap;
      int midpoint;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = 8'h00;
      req_tlast       = 1'b0;
      cycle_count     = 0;
      long_stall_done = 1'b0;
      scoreboard      = new();
      build_directed();
      build_random();
      midpoint = source_text_q.size() / 2;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idx = 0;
      while (idx < source_text_q.size()) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
         while (burst > 0 && idx < source_text_q.size()) begin
            send_request(source_text_q[idx]);
            idx++;
            burst--;
            if (idx == midpoint) begin
               // let the block drain completely before going on
               req_tvalid <= 1'b0;
               do @(negedge clock); while (scoreboard.pending() != 0);
            end
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) hold_sender(gap);
      end
      req_tvalid <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      scoreboard.flag_leftover();
      if (scoreboard.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/qts_pkg.sv
sv/qts_scan.sv
sv/qts_rsp_queue.sv
sv/quoted_token_splitter.sv
verif/quoted_token_splitter_test.sv
